FILE: rtl/core/ffa_pkg.sv
// Shared constants, codes, command and status types for the first-fit allocator.
package ffa_pkg;

   localparam int POOL_BYTES = 64;
   localparam int MAX_BLOCKS = 16;
   localparam int AW         = $clog2(POOL_BYTES);
   localparam int LW         = $clog2(POOL_BYTES + 1);
   localparam int IW         = $clog2(MAX_BLOCKS);

   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_COMPACT = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOSPACE  = 3'd1;
   localparam logic [2:0] ST_BADSIZE  = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_NOMOVE   = 3'd5;

   localparam logic [3:0] CMD_NOP       = 4'd0;
   localparam logic [3:0] CMD_START     = 4'd1;
   localparam logic [3:0] CMD_A_CHECK   = 4'd2;
   localparam logic [3:0] CMD_A_STEP    = 4'd3;
   localparam logic [3:0] CMD_A_COMMIT  = 4'd4;
   localparam logic [3:0] CMD_A_FAIL    = 4'd5;
   localparam logic [3:0] CMD_F_STEP    = 4'd6;
   localparam logic [3:0] CMD_F_HIT     = 4'd7;
   localparam logic [3:0] CMD_F_MISS    = 4'd8;
   localparam logic [3:0] CMD_C_STEP    = 4'd9;
   localparam logic [3:0] CMD_C_MOVE    = 4'd10;
   localparam logic [3:0] CMD_C_SKIP    = 4'd11;
   localparam logic [3:0] CMD_C_END     = 4'd12;
   localparam logic [3:0] CMD_EMIT_MID  = 4'd13;
   localparam logic [3:0] CMD_EMIT_LAST = 4'd14;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic bad_size;
      logic table_full;
      logic fit;
      logic scan_end;
      logic idx_end;
      logic f_hit;
      logic best_found;
      logic need_move;
      logic pend_valid;
   } stat_type;

   function automatic logic [POOL_BYTES-1:0] run_mask(input logic [AW-1:0] start,
                                                      input logic [LW-1:0] len);
      logic [POOL_BYTES:0] m;
      m = ({{POOL_BYTES{1'b0}}, 1'b1} << len) - {{POOL_BYTES{1'b0}}, 1'b1};
      m = m << start;
      return m[POOL_BYTES-1:0];
   endfunction

endpackage

FILE: rtl/core/first_fit_allocator_with_compaction_top.sv
// Top level of the first-fit byte pool allocator with compaction.
// Request channel (req_): kind 0 allocate req_size bytes, 1 free the block
// starting at req_address, 2 compact, 3 ignored with no result.
// Result channel (rsp_): status, block_address, new_address and last; one
// item per allocate or free, one per moved block on compact (or a single
// "nothing moved" item), last set on the final item of a request.
// One request is worked on at a time; req_ready is high only when idle.
// Allocate: the first-fit scan examines one pool byte per cycle. Free: the
// block table is searched one entry per cycle. Compact: for each block
// walked, a 16-entry scan picks the next block in address order, then a
// decision step follows; each moved block after the first also passes
// through an emit state that waits for room in the output register.
// Results pass through a one-item output register; when the receiver
// stalls, the sequencer waits before loading the next item.
// Reset (synchronous, active high) clears the occupancy map, the table's
// valid marks and all handshake state; it is ready the cycle after.
module first_fit_allocator_with_compaction_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [6:0] req_size,
   input  logic [5:0] req_address,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_block_address,
   output logic [5:0] rsp_new_address,
   output logic       rsp_last
);
   import ffa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffa_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_size          (req_size),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_new_address   (rsp_new_address),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: rtl/core/ffa_ctrl.sv
// Sequencing state machine for allocate, free and compact requests.
module ffa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  ffa_pkg::stat_type stat,
   output ffa_pkg::cmd_type  cmd
);
   import ffa_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ACHK  = 3'd1;
   localparam logic [2:0] S_ASCAN = 3'd2;
   localparam logic [2:0] S_FREE  = 3'd3;
   localparam logic [2:0] S_CSCAN = 3'd4;
   localparam logic [2:0] S_CDEC  = 3'd5;
   localparam logic [2:0] S_CEMIT = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = CMD_NOP;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = CMD_START;
               case (req_kind)
                  KIND_ALLOC:   state_in = S_ACHK;
                  KIND_FREE:    state_in = S_FREE;
                  KIND_COMPACT: state_in = S_CSCAN;
                  default:      state_in = S_IDLE;
               endcase
            end
         end
         S_ACHK: begin
            if (stat.bad_size || stat.table_full) begin
               cmd.op   = CMD_A_CHECK;
               state_in = S_OUT;
            end else begin
               state_in = S_ASCAN;
            end
         end
         S_ASCAN: begin
            if (stat.fit) begin
               cmd.op   = CMD_A_COMMIT;
               state_in = S_OUT;
            end else if (stat.scan_end) begin
               cmd.op   = CMD_A_FAIL;
               state_in = S_OUT;
            end else begin
               cmd.op = CMD_A_STEP;
            end
         end
         S_FREE: begin
            if (stat.f_hit) begin
               cmd.op   = CMD_F_HIT;
               state_in = S_OUT;
            end else if (stat.idx_end) begin
               cmd.op   = CMD_F_MISS;
               state_in = S_OUT;
            end else begin
               cmd.op = CMD_F_STEP;
            end
         end
         S_CSCAN: begin
            cmd.op = CMD_C_STEP;
            if (stat.idx_end) begin
               state_in = S_CDEC;
            end
         end
         S_CDEC: begin
            if (!stat.best_found) begin
               cmd.op   = CMD_C_END;
               state_in = S_OUT;
            end else if (stat.need_move) begin
               if (stat.pend_valid) begin
                  state_in = S_CEMIT;
               end else begin
                  cmd.op   = CMD_C_MOVE;
                  state_in = S_CSCAN;
               end
            end else begin
               cmd.op   = CMD_C_SKIP;
               state_in = S_CSCAN;
            end
         end
         S_CEMIT: begin
            if (stat.out_free) begin
               cmd.op   = CMD_EMIT_MID;
               state_in = S_CDEC;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.op   = CMD_EMIT_LAST;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/ffa_dpath.sv
// Occupancy map, block table, scan counters and result register.
module ffa_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  ffa_pkg::cmd_type       cmd,
   output ffa_pkg::stat_type      stat,
   input  logic [6:0]             req_size,
   input  logic [5:0]             req_address,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [5:0]             rsp_block_address,
   output logic [5:0]             rsp_new_address,
   output logic                   rsp_last
);
   import ffa_pkg::*;

   logic [POOL_BYTES-1:0] occ_ff, occ_in;
   logic [AW-1:0]         tstart_ff [MAX_BLOCKS];
   logic [LW-1:0]         tlen_ff   [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] tvalid_ff, tvalid_in;

   logic [6:0]    size_ff;
   logic [5:0]    addr_ff;
   logic [AW-1:0] scan_ff, scan_in;
   logic [LW-1:0] run_ff, run_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [LW-1:0] cursor_ff, cursor_in;
   logic [IW-1:0] best_ff, best_in;
   logic [AW-1:0] bstart_ff, bstart_in;
   logic [LW-1:0] blen_ff, blen_in;
   logic          bfound_ff, bfound_in;
   logic          pvalid_ff, pvalid_in;
   logic [2:0]    pstat_ff, pstat_in;
   logic [5:0]    pa_ff, pa_in;
   logic [5:0]    pna_ff, pna_in;
   logic          ovalid_ff, ovalid_in;
   logic [2:0]    ostat_ff;
   logic [5:0]    oa_ff, ona_ff;
   logic          olast_ff;

   logic [IW-1:0] free_slot;
   logic          out_free;
   logic [LW-1:0] run_next;
   logic [LW-1:0] fit_start;
   logic [AW-1:0] cur_start;
   logic [LW-1:0] cur_len;
   logic          cur_valid;
   logic          cand;
   logic          emit;

   assign cur_start = tstart_ff[idx_ff];
   assign cur_len   = tlen_ff[idx_ff];
   assign cur_valid = tvalid_ff[idx_ff];
   assign out_free  = !ovalid_ff || rsp_ready;
   assign run_next  = occ_ff[scan_ff] ? '0 : run_ff + LW'(1);
   assign fit_start = LW'(scan_ff) + LW'(1) - LW'(size_ff);
   assign cand      = cur_valid && ({1'b0, cur_start} >= cursor_ff) &&
                      (!bfound_ff || (cur_start < bstart_ff));
   assign emit      = (cmd.op == CMD_EMIT_MID) || (cmd.op == CMD_EMIT_LAST);

   always_comb begin
      free_slot = '0;
      for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
         if (!tvalid_ff[i]) free_slot = IW'(i);
      end
   end

   always_comb begin
      stat.out_free   = out_free;
      stat.bad_size   = (size_ff == 7'd0) || (LW'(size_ff) > LW'(POOL_BYTES));
      stat.table_full = &tvalid_ff;
      stat.fit        = !occ_ff[scan_ff] && (run_next == LW'(size_ff));
      stat.scan_end   = (scan_ff == AW'(POOL_BYTES - 1));
      stat.idx_end    = (idx_ff == IW'(MAX_BLOCKS - 1));
      stat.f_hit      = cur_valid && (cur_start == addr_ff);
      stat.best_found = bfound_ff;
      stat.need_move  = ({1'b0, bstart_ff} != cursor_ff);
      stat.pend_valid = pvalid_ff;
   end

   always_comb begin
      occ_in    = occ_ff;
      tvalid_in = tvalid_ff;
      scan_in   = scan_ff;
      run_in    = run_ff;
      idx_in    = idx_ff;
      cursor_in = cursor_ff;
      best_in   = best_ff;
      bstart_in = bstart_ff;
      blen_in   = blen_ff;
      bfound_in = bfound_ff;
      pvalid_in = pvalid_ff;
      pstat_in  = pstat_ff;
      pa_in     = pa_ff;
      pna_in    = pna_ff;
      ovalid_in = ovalid_ff;
      if (rsp_ready) ovalid_in = 1'b0;
      if (emit) ovalid_in = 1'b1;
      case (cmd.op)
         CMD_START: begin
            scan_in   = '0;
            run_in    = '0;
            idx_in    = '0;
            cursor_in = '0;
            bfound_in = 1'b0;
            pvalid_in = 1'b0;
         end
         CMD_A_CHECK: begin
            pstat_in = stat.bad_size ? ST_BADSIZE : ST_FULL;
            pa_in    = '0;
            pna_in   = '0;
         end
         CMD_A_STEP: begin
            scan_in = scan_ff + AW'(1);
            run_in  = run_next;
         end
         CMD_A_COMMIT: begin
            tvalid_in[free_slot] = 1'b1;
            occ_in   = occ_ff | run_mask(AW'(fit_start), LW'(size_ff));
            pstat_in = ST_OK;
            pa_in    = 6'(fit_start);
            pna_in   = '0;
         end
         CMD_A_FAIL: begin
            pstat_in = ST_NOSPACE;
            pa_in    = '0;
            pna_in   = '0;
         end
         CMD_F_STEP: begin
            idx_in = idx_ff + IW'(1);
         end
         CMD_F_HIT: begin
            tvalid_in[idx_ff] = 1'b0;
            occ_in   = occ_ff & ~run_mask(cur_start, cur_len);
            pstat_in = ST_OK;
            pa_in    = addr_ff;
            pna_in   = '0;
         end
         CMD_F_MISS: begin
            pstat_in = ST_NOTFOUND;
            pa_in    = addr_ff;
            pna_in   = '0;
         end
         CMD_C_STEP: begin
            idx_in = idx_ff + IW'(1);
            if (cand) begin
               best_in   = idx_ff;
               bstart_in = cur_start;
               blen_in   = cur_len;
               bfound_in = 1'b1;
            end
         end
         CMD_C_MOVE: begin
            occ_in    = (occ_ff & ~run_mask(bstart_ff, blen_ff)) |
                        run_mask(AW'(cursor_ff), blen_ff);
            pvalid_in = 1'b1;
            pstat_in  = ST_OK;
            pa_in     = 6'(bstart_ff);
            pna_in    = 6'(cursor_ff);
            cursor_in = cursor_ff + blen_ff;
            idx_in    = '0;
            bfound_in = 1'b0;
         end
         CMD_C_SKIP: begin
            cursor_in = cursor_ff + blen_ff;
            idx_in    = '0;
            bfound_in = 1'b0;
         end
         CMD_C_END: begin
            if (!pvalid_ff) begin
               pstat_in = ST_NOMOVE;
               pa_in    = '0;
               pna_in   = '0;
            end
         end
         CMD_EMIT_MID: begin
            pvalid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         tvalid_ff <= '0;
         ovalid_ff <= 1'b0;
         pvalid_ff <= 1'b0;
         bfound_ff <= 1'b0;
      end else begin
         occ_ff    <= occ_in;
         tvalid_ff <= tvalid_in;
         ovalid_ff <= ovalid_in;
         pvalid_ff <= pvalid_in;
         bfound_ff <= bfound_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_START) begin
         size_ff <= req_size;
         addr_ff <= req_address;
      end
      if (cmd.op == CMD_A_COMMIT) begin
         tstart_ff[free_slot] <= AW'(fit_start);
         tlen_ff[free_slot]   <= LW'(size_ff);
      end
      if (cmd.op == CMD_C_MOVE) begin
         tstart_ff[best_ff] <= AW'(cursor_ff);
      end
      if (emit) begin
         ostat_ff <= pstat_ff;
         oa_ff    <= pa_ff;
         ona_ff   <= pna_ff;
         olast_ff <= (cmd.op == CMD_EMIT_LAST);
      end
      scan_ff   <= scan_in;
      run_ff    <= run_in;
      idx_ff    <= idx_in;
      cursor_ff <= cursor_in;
      best_ff   <= best_in;
      bstart_ff <= bstart_in;
      blen_ff   <= blen_in;
      pstat_ff  <= pstat_in;
      pa_ff     <= pa_in;
      pna_ff    <= pna_in;
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_status        = ostat_ff;
   assign rsp_block_address = oa_ff;
   assign rsp_new_address   = ona_ff;
   assign rsp_last          = olast_ff;

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result loaded over an untaken item");

   a_move_legal: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CMD_C_MOVE) |-> (bfound_ff && (cursor_ff < {1'b0, bstart_ff})))
      else $error("compaction move without a block above the cursor");

   a_commit_marks: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == CMD_A_COMMIT) |=> occ_ff[$past(AW'(fit_start))])
      else $error("allocated start not marked used");

endmodule
